// File: hw/rtl/tsrs_pkg.sv
`default_nettype none

package tsrs_pkg;

   localparam int SUM_W  = 16;
   localparam int CNT_W  = 4;
   localparam int ADDR_W = 16;
   localparam int DATA_W = 32;

   localparam logic [ADDR_W-1:0] ADDR_START  = 16'h0000;
   localparam logic [ADDR_W-1:0] ADDR_RESULT = 16'h0010;

   localparam int NUM_RESET_TERMS = 10;
   localparam logic [11:0] RESET_TERMS [NUM_RESET_TERMS] = '{
      12'hEEF, 12'hBEE, 12'hDEA, 12'h0B0, 12'hB00,
      12'h123, 12'h987, 12'h645, 12'hB23, 12'hB63
   };

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      RESP_OK    = 2'd0,
      RESP_ADDR  = 2'd1,
      RESP_BURST = 2'd2,
      RESP_BE    = 2'd3
   } resp_type;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_PENDING = 2'd1,
      PHASE_BUSY    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      RD_NONE = 2'd0,
      RD_BUSY = 2'd1,
      RD_SUM  = 2'd2,
      RD_TERM = 2'd3
   } rd_src_type;

   typedef struct packed {
      resp_type   resp;
      rd_src_type rd_src;
      logic       wr_start;
      logic       wr_term;
      logic       tick;
   } dec_type;

   typedef struct packed {
      logic tick;
      logic start;
   } run_cmd_type;

   typedef struct packed {
      logic             busy_now;
      logic             busy_next;
      logic             done_next;
      logic [SUM_W-1:0] sum;
   } run_stat_type;

   function automatic logic [11:0] reset_term(input int idx, input int bits);
      logic [11:0] mask;
      mask = 12'((1 << bits) - 1);
      if (idx < NUM_RESET_TERMS) begin
         return RESET_TERMS[idx] & mask;
      end
      return 12'h000;
   endfunction

   function automatic logic [SUM_W-1:0] reset_total(input int num, input int bits);
      logic [SUM_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < num; i++) begin
         acc = acc + SUM_W'(reset_term(i, bits));
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tsrs_req_if.sv
`default_nettype none

interface tsrs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] byte_address;
   logic [31:0] write_data;
   logic        has_byte_enables;
   logic        stream_too_narrow;

   modport source (
      output valid, command, byte_address, write_data, has_byte_enables,
             stream_too_narrow,
      input  ready
   );

   modport sink (
      input  valid, command, byte_address, write_data, has_byte_enables,
             stream_too_narrow,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/tsrs_rsp_if.sv
`default_nettype none

interface tsrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic [1:0]  response;
   logic        busy_res;
   logic        done_res;

   modport source (
      output valid, read_data, response, busy_res, done_res,
      input  ready
   );

   modport sink (
      input  valid, read_data, response, busy_res, done_res,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/tsrs_decode.sv
`default_nettype none

module tsrs_decode
   import tsrs_pkg::*;
#(
   parameter int NUM_TERMS  = 10,
   parameter int TERMS_BASE = 32,
   parameter int IDX_W      = 4
) (
   input  wire logic [1:0]        command,
   input  wire logic [ADDR_W-1:0] byte_address,
   input  wire logic              has_byte_enables,
   input  wire logic              stream_too_narrow,
   output dec_type                dec,
   output logic [IDX_W-1:0]       term_idx
);

   logic [ADDR_W-1:0] diff;
   logic              term_hit;
   cmd_type           cmd;

   assign cmd      = cmd_type'(command);
   assign diff     = byte_address - ADDR_W'(TERMS_BASE);
   assign term_hit = (byte_address >= ADDR_W'(TERMS_BASE)) &&
                     (diff[ADDR_W-1:2] < (ADDR_W-2)'(NUM_TERMS));
   assign term_idx = diff[IDX_W+1:2];

   always_comb begin
      dec = '{resp: RESP_OK, rd_src: RD_NONE, wr_start: 1'b0, wr_term: 1'b0,
              tick: 1'b0};
      case (cmd)
         CMD_TICK: begin
            dec.tick = 1'b1;
         end
         CMD_READ, CMD_WRITE: begin
            if (has_byte_enables) begin
               dec.resp = RESP_BE;
            end else if (stream_too_narrow) begin
               dec.resp = RESP_BURST;
            end else if (byte_address[1:0] != 2'b00) begin
               dec.resp = RESP_ADDR;
            end else if (cmd == CMD_READ) begin
               if (byte_address == ADDR_START) begin
                  dec.rd_src = RD_BUSY;
               end else if (byte_address == ADDR_RESULT) begin
                  dec.rd_src = RD_SUM;
               end else if (term_hit) begin
                  dec.rd_src = RD_TERM;
               end else begin
                  dec.resp = RESP_ADDR;
               end
            end else begin
               if (byte_address == ADDR_START) begin
                  dec.wr_start = 1'b1;
               end else if (term_hit) begin
                  dec.wr_term = 1'b1;
               end else begin
                  dec.resp = RESP_ADDR;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/tsrs_regfile.sv
`default_nettype none

module tsrs_regfile
   import tsrs_pkg::*;
#(
   parameter int               NUM_TERMS = 10,
   parameter int               TERM_BITS = 12,
   parameter int               IDX_W     = 4,
   parameter logic [SUM_W-1:0] RESET_SUM = '0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [IDX_W-1:0]     idx,
   input  wire logic [TERM_BITS-1:0] wr_data,
   output logic [TERM_BITS-1:0]      rd_data,
   output logic [SUM_W-1:0]          total
);

   logic [TERM_BITS-1:0] term_ff [NUM_TERMS];
   logic [SUM_W-1:0]     total_ff;
   logic [SUM_W-1:0]     total_in;

   // running total keeps the sum of all terms ready at any time
   assign rd_data  = term_ff[idx];
   assign total_in = total_ff - SUM_W'(rd_data) + SUM_W'(wr_data);
   assign total    = total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TERMS; i++) begin
            term_ff[i] <= TERM_BITS'(reset_term(i, TERM_BITS));
         end
         total_ff <= RESET_SUM;
      end else if (wr_en) begin
         term_ff[idx] <= wr_data;
         total_ff     <= total_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/tsrs_run_ctrl.sv
`default_nettype none

module tsrs_run_ctrl
   import tsrs_pkg::*;
#(
   parameter logic [CNT_W-1:0] START_CNT = 4'd2,
   parameter logic [CNT_W-1:0] RUN_CNT   = 4'd10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire run_cmd_type      cmd,
   input  wire logic [SUM_W-1:0] total,
   output run_stat_type          stat
);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_dec;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         done_ff  <= done_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      done_in  = done_ff;
      cnt_dec  = (cnt_ff != '0) ? cnt_ff - 1'b1 : cnt_ff;
      if (cmd.tick) begin
         case (phase_ff)
            PHASE_PENDING: begin
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  sum_in   = '0;
                  done_in  = 1'b0;
                  phase_in = PHASE_BUSY;
                  cnt_in   = RUN_CNT;
               end
            end
            PHASE_BUSY: begin
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  sum_in   = total;
                  phase_in = PHASE_IDLE;
                  done_in  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.start && (phase_ff == PHASE_IDLE)) begin
         phase_in = PHASE_PENDING;
         cnt_in   = START_CNT;
         if (START_CNT == '0) begin
            sum_in   = '0;
            done_in  = 1'b0;
            phase_in = PHASE_BUSY;
            cnt_in   = RUN_CNT;
         end
      end
      stat.busy_now  = (phase_ff == PHASE_BUSY);
      stat.busy_next = (phase_in == PHASE_BUSY);
      stat.done_next = done_in;
      stat.sum       = sum_ff;
   end

`ifndef SYNTHESIS
   a_busy_not_done: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_BUSY |-> !done_ff)
      else $error("done set during a run");

   a_idle_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_IDLE |-> cnt_ff == '0)
      else $error("countdown left over while idle");

   a_busy_cnt_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_BUSY |-> (cnt_ff <= RUN_CNT && cnt_ff != '0))
      else $error("run countdown out of range");

   a_run_cause: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != phase_in) |-> (cmd.tick || cmd.start))
      else $error("phase changed without a tick or start");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/term_sum_register_slave.sv
// term_sum_register_slave
// Register-mapped slave that sums a table of term registers.
// req (sink): one transaction per item: a word read, a word write or a clock
//   tick, selected by command. Map: start at 0x00 (read gives busy), result
//   at 0x10 (read only), term i at 0x20 + 4*i.
// rsp (source): exactly one transaction per request, in order, carrying
//   read_data, response code and the busy and done flags after the request.
// Each request passes one input register and one result register, with the
//   decode, term file read and run control between them. Throughput is one
//   transaction per cycle while the receiver keeps rsp.ready high.
// The sum of the terms is kept as a running total updated on each term
//   write, so finishing a run is a single register load.
// A start write arms a run; START_DELAY ticks later the run begins and
//   RUN_TICKS ticks after that the sum is loaded and done rises.
// Reset (synchronous) loads the default terms, clears result, done and
//   countdown, and leaves both stages empty.
// When the receiver holds rsp.ready low, the result register holds its
//   transaction, the input register takes one more request, then req.ready
//   falls until the result is taken.
`default_nettype none

module term_sum_register_slave
   import tsrs_pkg::*;
#(
   parameter int NUM_TERMS   = 10,
   parameter int TERM_BITS   = 12,
   parameter int RUN_TICKS   = 10,
   parameter int START_DELAY = 2,
   parameter int TERMS_BASE  = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tsrs_req_if.sink   req,
   tsrs_rsp_if.source rsp
);

   localparam int               IDX_W     = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;
   localparam logic [SUM_W-1:0] RESET_SUM = reset_total(NUM_TERMS, TERM_BITS);

   logic              in_valid_ff;
   logic [1:0]        cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic              be_ff;
   logic              narrow_ff;

   logic              rsp_valid_ff;
   logic [SUM_W-1:0]  rdata_ff, rdata_in;
   resp_type          resp_ff;
   logic              busy_ff;
   logic              done_ff;

   logic                 out_ready;
   logic                 in_ready;
   logic                 advance;
   dec_type              dec;
   logic [IDX_W-1:0]     term_idx;
   logic [TERM_BITS-1:0] term_rd;
   logic [SUM_W-1:0]     total;
   run_cmd_type          run_cmd;
   run_stat_type         stat;

   assign out_ready = !rsp_valid_ff || rsp.ready;
   assign in_ready  = !in_valid_ff || out_ready;
   assign advance   = in_valid_ff && out_ready;

   assign req.ready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req.valid) begin
         cmd_ff    <= req.command;
         addr_ff   <= req.byte_address;
         wdata_ff  <= req.write_data;
         be_ff     <= req.has_byte_enables;
         narrow_ff <= req.stream_too_narrow;
      end
   end

   tsrs_decode #(
      .NUM_TERMS  (NUM_TERMS),
      .TERMS_BASE (TERMS_BASE),
      .IDX_W      (IDX_W)
   ) u_decode (
      .command           (cmd_ff),
      .byte_address      (addr_ff),
      .has_byte_enables  (be_ff),
      .stream_too_narrow (narrow_ff),
      .dec               (dec),
      .term_idx          (term_idx)
   );

   tsrs_regfile #(
      .NUM_TERMS (NUM_TERMS),
      .TERM_BITS (TERM_BITS),
      .IDX_W     (IDX_W),
      .RESET_SUM (RESET_SUM)
   ) u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (advance && dec.wr_term),
      .idx     (term_idx),
      .wr_data (wdata_ff[TERM_BITS-1:0]),
      .rd_data (term_rd),
      .total   (total)
   );

   assign run_cmd = '{tick: advance && dec.tick, start: advance && dec.wr_start};

   tsrs_run_ctrl #(
      .START_CNT (CNT_W'(START_DELAY)),
      .RUN_CNT   (CNT_W'(RUN_TICKS))
   ) u_run_ctrl (
      .clock (clock),
      .reset (reset),
      .cmd   (run_cmd),
      .total (total),
      .stat  (stat)
   );

   always_comb begin
      case (dec.rd_src)
         RD_BUSY: rdata_in = SUM_W'(stat.busy_now);
         RD_SUM:  rdata_in = stat.sum;
         RD_TERM: rdata_in = SUM_W'(term_rd);
         default: rdata_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rdata_ff <= rdata_in;
         resp_ff  <= dec.resp;
         busy_ff  <= stat.busy_next;
         done_ff  <= stat.done_next;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = rdata_ff;
   assign rsp.response  = resp_ff;
   assign rsp.busy_res  = busy_ff;
   assign rsp.done_res  = done_ff;

endmodule

`default_nettype wire

// File: tb/tsrs_sum_checker.sv
`timescale 1ns / 100ps

module tsrs_sum_checker
   import tsrs_pkg::*;
#(
   parameter int NUM_TERMS   = 10,
   parameter int TERM_BITS   = 12,
   parameter int RUN_TICKS   = 10,
   parameter int START_DELAY = 2,
   parameter int TERMS_BASE  = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   tsrs_req_if       req,
   tsrs_rsp_if       rsp,
   output int        fail_total,
   output int        owed_count
);

   localparam logic [11:0] TERM_MASK = 12'((1 << TERM_BITS) - 1);

   typedef struct packed {
      logic [15:0] read_data;
      resp_type    response;
      logic        busy;
      logic        done;
   } slave_rsp_type;

   logic [11:0]      term_regs [NUM_TERMS];
   logic [SUM_W-1:0] sum_reg;
   phase_type        phase;
   logic [CNT_W-1:0] countdown;
   logic             done_flag;
   slave_rsp_type    rsp_owed [$];

   task automatic note_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t: MISMATCH %s got 0x%0h want 0x%0h", $realtime, field, got, want);
      fail_total++;
   endtask

   function automatic void start_summing();
      sum_reg   = '0;
      done_flag = 1'b0;
      phase     = PHASE_BUSY;
      countdown = CNT_W'(RUN_TICKS);
   endfunction

   function automatic void finish_summing();
      logic [SUM_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < NUM_TERMS; i++) begin
         acc = acc + SUM_W'(term_regs[i]);
      end
      sum_reg   = acc;
      phase     = PHASE_IDLE;
      done_flag = 1'b1;
   endfunction

   // -1 when the address hits no term register
   function automatic int term_slot(input logic [15:0] addr);
      int off;
      if (int'(addr) < TERMS_BASE) begin
         return -1;
      end
      off = (int'(addr) - TERMS_BASE) >> 2;
      return (off < NUM_TERMS) ? off : -1;
   endfunction

   function automatic slave_rsp_type apply_bus_item(input cmd_type cmd,
                                                    input logic [15:0] addr,
                                                    input logic [31:0] wdata,
                                                    input logic be,
                                                    input logic narrow);
      slave_rsp_type r;
      int slot;
      r.read_data = '0;
      r.response  = RESP_OK;
      if (cmd == CMD_TICK) begin
         if (phase == PHASE_PENDING) begin
            if (countdown != 0) countdown--;
            if (countdown == 0) start_summing();
         end else if (phase == PHASE_BUSY) begin
            if (countdown != 0) countdown--;
            if (countdown == 0) finish_summing();
         end
      end else if (cmd == CMD_READ || cmd == CMD_WRITE) begin
         slot = term_slot(addr);
         if (be) begin
            r.response = RESP_BE;
         end else if (narrow) begin
            r.response = RESP_BURST;
         end else if (addr[1:0] != 2'b00) begin
            r.response = RESP_ADDR;
         end else if (cmd == CMD_READ) begin
            if (addr == ADDR_START) begin
               r.read_data = {15'd0, phase == PHASE_BUSY};
            end else if (addr == ADDR_RESULT) begin
               r.read_data = sum_reg;
            end else if (slot < 0) begin
               r.response = RESP_ADDR;
            end else begin
               r.read_data = 16'(term_regs[slot]);
            end
         end else begin
            if (addr == ADDR_START) begin
               if (phase == PHASE_IDLE) begin
                  phase     = PHASE_PENDING;
                  countdown = CNT_W'(START_DELAY);
                  if (countdown == 0) start_summing();
               end
            end else if (slot < 0) begin
               r.response = RESP_ADDR;
            end else begin
               term_regs[slot] = wdata[11:0] & TERM_MASK;
            end
         end
      end
      r.busy = (phase == PHASE_BUSY);
      r.done = done_flag;
      return r;
   endfunction

   always @(posedge clock) begin
      slave_rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_TERMS; i++) begin
            term_regs[i] = (i < NUM_RESET_TERMS) ? (RESET_TERMS[i] & TERM_MASK) : 12'h000;
         end
         sum_reg   = '0;
         phase     = PHASE_IDLE;
         countdown = '0;
         done_flag = 1'b0;
         rsp_owed.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (rsp_owed.size() == 0) begin
               note_mismatch("unexpected response", 32'(rsp.read_data), 32'h0);
            end else begin
               want = rsp_owed.pop_front();
               if (rsp.read_data !== want.read_data)
                  note_mismatch("read_data", 32'(rsp.read_data), 32'(want.read_data));
               if (rsp.response !== want.response)
                  note_mismatch("response", 32'(rsp.response), 32'(want.response));
               if (rsp.busy_res !== want.busy)
                  note_mismatch("busy_res", 32'(rsp.busy_res), 32'(want.busy));
               if (rsp.done_res !== want.done)
                  note_mismatch("done_res", 32'(rsp.done_res), 32'(want.done));
            end
         end
         if (req.valid && req.ready) begin
            rsp_owed.push_back(apply_bus_item(cmd_type'(req.command), req.byte_address,
                                              req.write_data, req.has_byte_enables,
                                              req.stream_too_narrow));
         end
      end
      owed_count <= rsp_owed.size();
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tsrs_pkg::*;

   localparam int NUM_TERMS   = 10;
   localparam int TERM_BITS   = 12;
   localparam int RUN_TICKS   = 10;
   localparam int START_DELAY = 2;
   localparam int TERMS_BASE  = 32;
   localparam int STALL_LIMIT = 1000;

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   fail_total;
   int   owed_count;
   int   quiet_cycles;

   tsrs_req_if req_if ();
   tsrs_rsp_if rsp_if ();

   term_sum_register_slave #(
      .NUM_TERMS   (NUM_TERMS),
      .TERM_BITS   (TERM_BITS),
      .RUN_TICKS   (RUN_TICKS),
      .START_DELAY (START_DELAY),
      .TERMS_BASE  (TERMS_BASE)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   tsrs_sum_checker #(
      .NUM_TERMS   (NUM_TERMS),
      .TERM_BITS   (TERM_BITS),
      .RUN_TICKS   (RUN_TICKS),
      .START_DELAY (START_DELAY),
      .TERMS_BASE  (TERMS_BASE)
   ) u_sum_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .fail_total (fail_total),
      .owed_count (owed_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input cmd_type cmd, input logic [15:0] addr,
                            input logic [31:0] wdata, input logic be, input logic narrow);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid             <= 1'b1;
      req_if.command           <= cmd;
      req_if.byte_address      <= addr;
      req_if.write_data        <= wdata;
      req_if.has_byte_enables  <= be;
      req_if.stream_too_narrow <= narrow;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      cmd_type     cmd;
      logic [15:0] addr;
      int          pick;
      int          apick;

      idle_pct                 = 0;
      stall_pct                = 0;
      reset                    = 1'b1;
      rsp_if.ready             = 1'b0;
      req_if.valid             = 1'b0;
      req_if.command           = CMD_TICK;
      req_if.byte_address      = '0;
      req_if.write_data        = '0;
      req_if.has_byte_enables  = 1'b0;
      req_if.stream_too_narrow = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(CMD_READ,  ADDR_START,  32'h0, 1'b0, 1'b0);
      send_item(CMD_READ,  ADDR_RESULT, 32'h0, 1'b0, 1'b0);
      send_item(CMD_READ,  16'h0020,    32'h0, 1'b0, 1'b0);
      send_item(CMD_READ,  16'h0044,    32'h0, 1'b0, 1'b0);
      send_item(CMD_READ,  16'h0048,    32'h0, 1'b0, 1'b0);
      send_item(CMD_READ,  16'h0003,    32'h0, 1'b1, 1'b1);
      send_item(CMD_WRITE, 16'h0020,    32'h0, 1'b0, 1'b1);
      send_item(CMD_READ,  16'hFFFF,    32'h0, 1'b0, 1'b0);
      send_item(CMD_WRITE, ADDR_RESULT, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_item(CMD_WRITE, 16'h0020,    32'hFFFF_FFFF, 1'b0, 1'b0);
      send_item(CMD_WRITE, 16'h0044,    32'h0, 1'b0, 1'b0);
      send_item(CMD_NONE,  16'hFFFF,    32'hFFFF_FFFF, 1'b1, 1'b1);
      send_item(CMD_WRITE, ADDR_START,  32'h1, 1'b0, 1'b0);
      send_item(CMD_TICK,  16'h0,       32'h0, 1'b0, 1'b0);
      send_item(CMD_WRITE, ADDR_START,  32'h1, 1'b0, 1'b0);  // ignored: pending
      send_item(CMD_TICK,  16'h0,       32'h0, 1'b0, 1'b0);
      send_item(CMD_READ,  ADDR_START,  32'h0, 1'b0, 1'b0);
      send_item(CMD_WRITE, ADDR_START,  32'h1, 1'b0, 1'b0);  // ignored: busy
      repeat (RUN_TICKS) send_item(CMD_TICK, 16'h0, 32'h0, 1'b0, 1'b0);
      send_item(CMD_READ,  ADDR_RESULT, 32'h0, 1'b0, 1'b0);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 85; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 85; end
            default: begin idle_pct = 29; stall_pct = 29; end
         endcase
         for (int n = 0; n < 500; n++) begin
            pick  = $urandom_range(99);
            apick = $urandom_range(99);
            if (apick < 10)
               addr = ADDR_START;
            else if (apick < 20)
               addr = ADDR_RESULT;
            else if (apick < 75)
               addr = 16'(TERMS_BASE + 4 * $urandom_range(NUM_TERMS - 1));
            else if (apick < 85)
               addr = 16'($urandom) & 16'hFFFC;
            else
               addr = 16'($urandom);
            if (pick < 40)
               cmd = CMD_TICK;
            else if (pick < 62)
               cmd = CMD_READ;
            else if (pick < 85)
               cmd = CMD_WRITE;
            else if (pick < 97) begin
               cmd  = CMD_WRITE;
               addr = ADDR_START;
            end else
               cmd = cmd_type'($urandom_range(3));
            send_item(cmd, addr, $urandom, $urandom_range(19) == 0,
                      $urandom_range(19) == 0);
         end
      end
      req_if.valid <= 1'b0;

      while (owed_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_total == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/tsrs_pkg.sv
hw/rtl/tsrs_req_if.sv
hw/rtl/tsrs_rsp_if.sv
hw/rtl/tsrs_decode.sv
hw/rtl/tsrs_regfile.sv
hw/rtl/tsrs_run_ctrl.sv
hw/rtl/term_sum_register_slave.sv
tb/tsrs_sum_checker.sv
tb/testbench.sv
